// ----- hdl/pdr_pkg.sv -----
`default_nettype none
package pdr_pkg;

   localparam int CORDIC_STEPS = 20;
   localparam int CORDIC_TAB_N = 24;
   localparam int CORDIC_RUN   = (CORDIC_STEPS < CORDIC_TAB_N) ? CORDIC_STEPS : CORDIC_TAB_N;
   localparam int CORDIC_CNT_W = 5;

   localparam int CS_W    = 26;   // cordic x/y, Q2.22 plus growth
   localparam int ANG_W   = 32;   // cordic angle, 2^-32 turn
   localparam int MUL_A_W = 40;
   localparam int MUL_B_W = 32;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W = $clog2(MUL_B_W);

   localparam logic signed [CS_W-1:0] CORDIC_GAIN = CS_W'(2547003);
   localparam logic [MUL_B_W-1:0]     RAD_TO_TURN = MUL_B_W'(683565276);

   localparam logic [20:0] PERIOD_RESET   = 21'd10486;
   localparam logic [23:0] GAP_RESET      = 24'd1048576;
   localparam logic [22:0] DEADZONE_RESET = 23'd66;

   localparam logic [1:0] REG_UPDATE_PERIOD = 2'd0;
   localparam logic [1:0] REG_GAP_LIMIT     = 2'd1;
   localparam logic [1:0] REG_DEADZONE      = 2'd2;

   function automatic logic [ANG_W-1:0] atan_entry(input logic [CORDIC_CNT_W-1:0] i);
      logic [ANG_W-1:0] r;
      unique case (i)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/pdr_smul.sv -----
`default_nettype none
module pdr_smul import pdr_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic signed [MUL_A_W-1:0] a,
   input  wire logic signed [MUL_B_W-1:0] b,
   output logic                           done,
   output logic signed [MUL_P_W-1:0]      prod
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [MUL_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [MUL_A_W-1:0]      a_ff, a_in;
   logic [MUL_A_W:0]        hi_ff, hi_in;
   logic [MUL_B_W-1:0]      lo_ff, lo_in;
   logic [MUL_A_W:0]        addend, sum;
   logic                    last;

   // one multiplier bit per cycle, sign bit subtracts
   always_comb begin
      addend  = lo_ff[0] ? {a_ff[MUL_A_W-1], a_ff} : '0;
      last    = (cnt_ff == MUL_CNT_W'(MUL_B_W - 1));
      sum     = last ? hi_ff - addend : hi_ff + addend;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = a;
         hi_in   = '0;
         lo_in   = b;
      end else if (busy_ff) begin
         hi_in  = {sum[MUL_A_W], sum[MUL_A_W:1]};
         lo_in  = {sum[0], lo_ff[MUL_B_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff  <= a_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign done = done_ff;
   assign prod = {hi_ff[MUL_A_W-1:0], lo_ff};

endmodule
`default_nettype wire

// ----- hdl/pdr_cordic.sv -----
`default_nettype none
module pdr_cordic import pdr_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [23:0]            angle,
   output logic                        valid,
   output logic signed [CS_W-1:0]      cos_out,
   output logic signed [CS_W-1:0]      sin_out
);

   logic                          busy_ff, busy_in;
   logic                          valid_ff, valid_in;
   logic [CORDIC_CNT_W-1:0]       cnt_ff, cnt_in;
   logic signed [CS_W-1:0]        x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [ANG_W-1:0]       z_ff, z_in, z0;
   logic                          flip_ff, flip_in, wide;
   logic [ANG_W-1:0]              at;

   always_comb begin
      z0   = {angle, 8'b0};
      wide = (z0 > 32'sh40000000) || (z0 < -32'sh40000000);
      xs   = x_ff >>> cnt_ff;
      ys   = y_ff >>> cnt_ff;
      at   = atan_entry(cnt_ff);
      busy_in  = busy_ff;
      valid_in = valid_ff;
      cnt_in   = cnt_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      flip_in  = flip_ff;
      if (start) begin
         busy_in  = 1'b1;
         valid_in = 1'b0;
         cnt_in   = '0;
         x_in     = CORDIC_GAIN;
         y_in     = '0;
         // outside a quarter turn: rotate half a turn, negate at the end
         z_in     = wide ? {~z0[ANG_W-1], z0[ANG_W-2:0]} : z0;
         flip_in  = wide;
      end else if (busy_ff) begin
         if (!z_ff[ANG_W-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - $signed(at);
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + $signed(at);
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CORDIC_CNT_W'(CORDIC_RUN - 1)) begin
            busy_in  = 1'b0;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
   end

   assign valid   = valid_ff;
   assign cos_out = flip_ff ? -x_ff : x_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;

endmodule
`default_nettype wire

// ----- hdl/planar_dead_reckoning_integrator_unit.sv -----
// Planar dead-reckoning integrator.
// Input channel req_*: one velocity command per item (time stamp, forward
// speed, vertical speed, turn rate). The block drives req_stall high while
// it works on an item, so it holds one item at a time.
// Result channel rsp_*: one pose item (x, y, z, heading) for each command
// that integrates; commands that run backwards in time, fall inside the
// update period or exceed the gap limit give no result item.
// Sequencing: an item that gives no result frees the input after its check. An
// integrating item runs the CORDIC (in parallel) and five or six serial
// multiplies (each a launch, 32 bit steps, done) on one bit-serial
// multiplier, so the pose is out after the last multiply, and the next
// item is taken only once that pose is registered; that multiplier sets
// the rate unless rsp_stall holds a second pose.
// The pose is held in an output register; if rsp_stall is high the
// block keeps working and only waits when a second pose is ready.
// Configuration writes on csr_* are always taken (csr_ready is high) and
// must come only while the block is idle.
// Reset (synchronous, active high) clears pose, heading and last time to
// zero and loads the default register values.
`default_nettype none
module planar_dead_reckoning_integrator_unit import pdr_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [39:0]        req_now_time,
   input  wire logic signed [23:0] req_linear_speed,
   input  wire logic signed [23:0] req_vertical_speed,
   input  wire logic signed [23:0] req_turn_rate,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [39:0]      rsp_pos_x,
   output logic signed [39:0]      rsp_pos_y,
   output logic signed [39:0]      rsp_pos_z,
   output logic [23:0]             rsp_heading,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_wdata
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_LAUNCH = 3'd2;
   localparam logic [2:0] ST_WAIT   = 3'd3;
   localparam logic [2:0] ST_OUT    = 3'd4;

   localparam logic [2:0] OP_P = 3'd0;
   localparam logic [2:0] OP_X = 3'd1;
   localparam logic [2:0] OP_Y = 3'd2;
   localparam logic [2:0] OP_Z = 3'd3;
   localparam logic [2:0] OP_Q = 3'd4;
   localparam logic [2:0] OP_H = 3'd5;

   function automatic logic signed [39:0] sat40(input logic signed [41:0] v);
      logic signed [39:0] r;
      if (v[41:39] == 3'b000 || v[41:39] == 3'b111) r = v[39:0];
      else if (v[41]) r = {1'b1, 39'b0};
      else r = {1'b0, {39{1'b1}}};
      return r;
   endfunction

   logic [2:0]         state_ff, state_in, op_ff, op_in;
   logic [20:0]        period_ff, period_in;
   logic [23:0]        gap_ff, gap_in;
   logic [22:0]        dz_ff, dz_in;
   logic signed [39:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [23:0]        yaw_ff, yaw_in;
   logic [39:0]        last_ff, last_in;
   logic [39:0]        now_ff, now_in;
   logic signed [23:0] v_ff, v_in, vz_ff, vz_in, w_ff, w_in;
   logic [23:0]        dt_ff, dt_in;
   logic signed [36:0] p_ff, p_in;
   logic signed [32:0] q_ff, q_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [39:0] ox_ff, ox_in, oy_ff, oy_in, oz_ff, oz_in;
   logic [23:0]        oh_ff, oh_in;

   logic                       mul_start, mul_done, cor_start, cor_valid;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [MUL_P_W-1:0]  mul_prod;
   logic signed [CS_W-1:0]     cos_v, sin_v;

   logic [40:0]        diff;
   logic [48:0]        r49p, r49z, r49q;
   logic [63:0]        r64;
   logic [51:0]        r52;
   logic signed [33:0] xy_term;
   logic signed [41:0] xy_sum, z_sum;
   logic [23:0]        vz_abs;
   logic               z_moves, out_free;

   pdr_smul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   pdr_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (yaw_ff),
      .valid   (cor_valid),
      .cos_out (cos_v),
      .sin_out (sin_v)
   );

   always_comb begin
      diff    = {1'b0, now_ff} - {1'b0, last_ff};
      r49p    = mul_prod[48:0] + 49'd2048;
      r49z    = mul_prod[48:0] + 49'd524288;
      r49q    = mul_prod[48:0] + 49'd32768;
      r64     = mul_prod[63:0] + 64'd536870912;
      r52     = mul_prod[51:0] + 52'd134217728;
      xy_term = r64[63:30];
      xy_sum  = ((op_ff == OP_X) ? 42'(x_ff) : 42'(y_ff)) + 42'(xy_term);
      z_sum   = 42'(z_ff) + 42'($signed(r49z[48:20]));
      vz_abs  = vz_ff[23] ? 24'(-vz_ff) : 24'(vz_ff);
      z_moves = vz_abs > {1'b0, dz_ff};
      out_free = !rsp_valid_ff || !rsp_stall;

      unique case (op_ff)
         OP_P: begin mul_a = 40'(v_ff);  mul_b = {8'b0, dt_ff}; end
         OP_X: begin mul_a = 40'(p_ff);  mul_b = 32'(cos_v); end
         OP_Y: begin mul_a = 40'(p_ff);  mul_b = 32'(sin_v); end
         OP_Z: begin mul_a = 40'(vz_ff); mul_b = {8'b0, dt_ff}; end
         OP_Q: begin mul_a = 40'(w_ff);  mul_b = {8'b0, dt_ff}; end
         OP_H: begin mul_a = 40'(q_ff);  mul_b = RAD_TO_TURN; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase

      state_in  = state_ff;
      op_in     = op_ff;
      period_in = period_ff;
      gap_in    = gap_ff;
      dz_in     = dz_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      yaw_in    = yaw_ff;
      last_in   = last_ff;
      now_in    = now_ff;
      v_in      = v_ff;
      vz_in     = vz_ff;
      w_in      = w_ff;
      dt_in     = dt_ff;
      p_in      = p_ff;
      q_in      = q_ff;
      ox_in     = ox_ff;
      oy_in     = oy_ff;
      oz_in     = oz_ff;
      oh_in     = oh_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mul_start = 1'b0;
      cor_start = 1'b0;

      if (csr_valid) begin
         unique case (csr_index)
            REG_UPDATE_PERIOD: period_in = csr_wdata[20:0];
            REG_GAP_LIMIT:     gap_in    = csr_wdata[23:0];
            REG_DEADZONE:      dz_in     = csr_wdata[22:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               now_in   = req_now_time;
               v_in     = req_linear_speed;
               vz_in    = req_vertical_speed;
               w_in     = req_turn_rate;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            priority if (diff[40]) begin
               state_in = ST_IDLE;
            end else if (diff[39:0] > {16'b0, gap_ff}) begin
               last_in  = now_ff;
               state_in = ST_IDLE;
            end else if (diff[39:0] <= {19'b0, period_ff}) begin
               state_in = ST_IDLE;
            end else begin
               dt_in     = diff[23:0];
               cor_start = 1'b1;
               op_in     = OP_P;
               state_in  = ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            mul_start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (mul_done && cor_valid) begin
               state_in = ST_LAUNCH;
               unique case (op_ff)
                  OP_P: begin p_in = r49p[48:12]; op_in = OP_X; end
                  OP_X: begin x_in = sat40(xy_sum); op_in = OP_Y; end
                  OP_Y: begin
                     y_in  = sat40(xy_sum);
                     op_in = z_moves ? OP_Z : OP_Q;
                  end
                  OP_Z: begin z_in = sat40(z_sum); op_in = OP_Q; end
                  OP_Q: begin q_in = r49q[48:16]; op_in = OP_H; end
                  OP_H: begin
                     yaw_in   = yaw_ff + r52[51:28];
                     state_in = ST_OUT;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_OUT: begin
            if (out_free) begin
               ox_in        = x_ff;
               oy_in        = y_ff;
               oz_in        = z_ff;
               oh_in        = yaw_ff;
               rsp_valid_in = 1'b1;
               last_in      = now_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_P;
         period_ff    <= PERIOD_RESET;
         gap_ff       <= GAP_RESET;
         dz_ff        <= DEADZONE_RESET;
         x_ff         <= '0;
         y_ff         <= '0;
         z_ff         <= '0;
         yaw_ff       <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         period_ff    <= period_in;
         gap_ff       <= gap_in;
         dz_ff        <= dz_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         z_ff         <= z_in;
         yaw_ff       <= yaw_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff <= now_in;
      v_ff   <= v_in;
      vz_ff  <= vz_in;
      w_ff   <= w_in;
      dt_ff  <= dt_in;
      p_ff   <= p_in;
      q_ff   <= q_in;
      ox_ff  <= ox_in;
      oy_ff  <= oy_in;
      oz_ff  <= oz_in;
      oh_ff  <= oh_in;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pos_x   = ox_ff;
   assign rsp_pos_y   = oy_ff;
   assign rsp_pos_z   = oz_ff;
   assign rsp_heading = oh_ff;
   assign csr_ready   = 1'b1;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not held off after an item");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == ST_WAIT)
      else $error("multiply finished outside wait state");

   a_out_heading: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT && out_free |=> rsp_valid && rsp_heading == yaw_ff)
      else $error("emitted heading differs from state");

endmodule
`default_nettype wire
